@@ sv/miller_rabin_witness_test_core_macros.svh @@
// ----------------------------------------------------------------------------
// Miller-Rabin witness test core: assertion macros
// Shared property forms for the port checker. Each macro expects signals
// named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef MILLER_RABIN_WITNESS_TEST_CORE_MACROS_SVH
`define MILLER_RABIN_WITNESS_TEST_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MRWT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MRWT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/mrwt_pkg.sv @@
// ----------------------------------------------------------------------------
// mrwt_pkg
// Types and constants shared by the Miller-Rabin witness test core.
// ----------------------------------------------------------------------------
`default_nettype none

package mrwt_pkg;

  // Width of the candidate and witness ports.
  localparam int IO_WIDTH = 64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIV,
    ST_REDUCE,
    ST_SPLIT,
    ST_POW_BIT,
    ST_MUL_ACC,
    ST_POW_SQ,
    ST_MUL_B,
    ST_EVAL,
    ST_MUL_X,
    ST_SQ_EVAL,
    ST_FINISH
  } state_t;

  // Operand selection for the modular multiplier.
  typedef enum logic [1:0] {
    MUL_ACC_B,
    MUL_B_B,
    MUL_ACC_ACC
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    red_step;
    logic    split_step;
    logic    pow_init;
    logic    mul_start;
    mul_op_t mul_op;
    logic    wr_acc;
    logic    wr_b;
    logic    exp_shift;
    logic    s_dec;
    logic    set_res;
    logic    res_prime;
    logic    res_triv;
    logic    emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic trivial;
    logic triv_prime;
    logic red_last;
    logic d_odd;
    logic a_zero;
    logic e_bit;
    logic e_last;
    logic mul_done;
    logic x_one;
    logic x_nm1;
    logic s_last;
  } dp_status_t;

endpackage

`default_nettype wire

@@ sv/mrwt_modmul.sv @@
// ----------------------------------------------------------------------------
// mrwt_modmul
// Shift-add modular multiplier: one multiplier bit per cycle, two modular
// additions in parallel (accumulate and double). Operands must be below n.
// ----------------------------------------------------------------------------
`default_nettype none

module mrwt_modmul #(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] x_in,
  input  wire logic [W-1:0] y_in,
  input  wire logic [W-1:0] modulus,
  output logic              done,
  output logic [W-1:0]      product
);
  import mrwt_pkg::*;

  logic         busy;
  logic [W-1:0] acc;
  logic [W-1:0] x;
  logic [W-1:0] y;
  logic [W:0]   sum_acc;
  logic [W:0]   sum_dbl;
  logic [W:0]   mod_ext;
  logic [W-1:0] acc_next;
  logic [W-1:0] x_next;

  assign mod_ext = {1'b0, modulus};
  assign sum_acc = {1'b0, acc} + {1'b0, x};
  assign sum_dbl = {1'b0, x} + {1'b0, x};

  always_comb begin
    acc_next = (sum_acc >= mod_ext) ? W'(sum_acc - mod_ext) : sum_acc[W-1:0];
    x_next   = (sum_dbl >= mod_ext) ? W'(sum_dbl - mod_ext) : sum_dbl[W-1:0];
  end

  assign done    = busy && (y == '0);
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      x   <= x_in;
      y   <= y_in;
    end else if (busy && (y != '0)) begin
      if (y[0]) begin
        acc <= acc_next;
      end
      x <= x_next;
      y <= {1'b0, y[W-1:1]};
    end
  end

endmodule

`default_nettype wire

@@ sv/mrwt_datapath.sv @@
// ----------------------------------------------------------------------------
// mrwt_datapath
// Operand registers, witness reduction, n-1 splitting and the shared
// modular multiplier, driven by controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module mrwt_datapath #(
  parameter int W = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [W-1:0]          candidate,
  input  wire logic [W-1:0]          witness,
  input  wire mrwt_pkg::ctrl_cmd_t   cmd,
  output mrwt_pkg::dp_status_t       status,
  output logic                       res_prime,
  output logic                       res_triv
);
  import mrwt_pkg::*;

  localparam int SW = $clog2(W);

  logic [W-1:0]  n;
  logic [W-1:0]  nm1;
  logic [W-1:0]  wit;
  logic [W-1:0]  rem;
  logic [W-1:0]  dexp;
  logic [W-1:0]  acc;
  logic [SW-1:0] s_cnt;
  logic [SW-1:0] red_cnt;
  logic [W:0]    rem_sh;
  logic [W:0]    n_ext;
  logic [W-1:0]  rem_next;
  logic [W-1:0]  mul_x;
  logic [W-1:0]  mul_y;
  logic          mul_done;
  logic [W-1:0]  mul_prod;

  // Restoring reduction of the witness modulo n, one bit per step.
  assign n_ext  = {1'b0, n};
  assign rem_sh = {rem, wit[W-1]};
  assign rem_next = (rem_sh >= n_ext) ? W'(rem_sh - n_ext) : rem_sh[W-1:0];

  always_comb begin
    case (cmd.mul_op)
      MUL_ACC_B: begin
        mul_x = acc;
        mul_y = rem;
      end
      MUL_B_B: begin
        mul_x = rem;
        mul_y = rem;
      end
      MUL_ACC_ACC: begin
        mul_x = acc;
        mul_y = acc;
      end
      default: begin
        mul_x = acc;
        mul_y = acc;
      end
    endcase
  end

  mrwt_modmul #(.W(W)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mul_start),
    .x_in    (mul_x),
    .y_in    (mul_y),
    .modulus (n),
    .done    (mul_done),
    .product (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n       <= candidate;
      nm1     <= candidate - W'(1);
      dexp    <= candidate - W'(1);
      wit     <= witness;
      rem     <= '0;
      red_cnt <= '0;
      s_cnt   <= '0;
    end else begin
      if (cmd.red_step) begin
        rem     <= rem_next;
        wit     <= {wit[W-2:0], 1'b0};
        red_cnt <= red_cnt + SW'(1);
      end
      if (cmd.split_step) begin
        dexp  <= {1'b0, dexp[W-1:1]};
        s_cnt <= s_cnt + SW'(1);
      end
      if (cmd.exp_shift) begin
        dexp <= {1'b0, dexp[W-1:1]};
      end
      if (cmd.s_dec) begin
        s_cnt <= s_cnt - SW'(1);
      end
      if (cmd.wr_b) begin
        rem <= mul_prod;
      end
    end
    if (cmd.pow_init) begin
      acc <= W'(1);
    end else if (cmd.wr_acc) begin
      acc <= mul_prod;
    end
    if (cmd.set_res) begin
      res_prime <= cmd.res_prime;
      res_triv  <= cmd.res_triv;
    end
  end

  always_comb begin
    status.trivial    = (n[W-1:1] == '0) || !n[0];
    status.triv_prime = (n == W'(2));
    status.red_last   = (red_cnt == SW'(W - 1));
    status.d_odd      = dexp[0];
    status.a_zero     = (rem == '0);
    status.e_bit      = dexp[0];
    status.e_last     = (dexp[W-1:1] == '0);
    status.mul_done   = mul_done;
    status.x_one      = (acc == W'(1));
    status.x_nm1      = (acc == nm1);
    status.s_last     = (s_cnt == SW'(1));
  end

endmodule

`default_nettype wire

@@ sv/mrwt_ctrl.sv @@
// ----------------------------------------------------------------------------
// mrwt_ctrl
// Sequencer for one witness round: trivial checks, reduction, splitting,
// square-and-multiply exponentiation and the closing squarings.
// ----------------------------------------------------------------------------
`default_nettype none

module mrwt_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  out_free,
  input  wire mrwt_pkg::dp_status_t  status,
  output logic                       in_ready,
  output mrwt_pkg::ctrl_cmd_t        cmd
);
  import mrwt_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_TRIV;
      end
      ST_TRIV: begin
        state_next = status.trivial ? ST_FINISH : ST_REDUCE;
      end
      ST_REDUCE: begin
        if (status.red_last) state_next = ST_SPLIT;
      end
      ST_SPLIT: begin
        if (status.d_odd) state_next = status.a_zero ? ST_FINISH : ST_POW_BIT;
      end
      ST_POW_BIT: begin
        state_next = status.e_bit ? ST_MUL_ACC : ST_POW_SQ;
      end
      ST_MUL_ACC: begin
        if (status.mul_done) state_next = ST_POW_SQ;
      end
      ST_POW_SQ: begin
        state_next = status.e_last ? ST_EVAL : ST_MUL_B;
      end
      ST_MUL_B: begin
        if (status.mul_done) state_next = ST_POW_BIT;
      end
      ST_EVAL: begin
        if (status.x_one || status.x_nm1 || status.s_last) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_MUL_X;
        end
      end
      ST_MUL_X: begin
        if (status.mul_done) state_next = ST_SQ_EVAL;
      end
      ST_SQ_EVAL: begin
        if (status.x_nm1 || status.x_one || status.s_last) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_MUL_X;
        end
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.mul_op = MUL_ACC_B;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_TRIV: begin
        cmd.set_res   = status.trivial;
        cmd.res_prime = status.triv_prime;
        cmd.res_triv  = 1'b1;
      end
      ST_REDUCE: begin
        cmd.red_step = 1'b1;
      end
      ST_SPLIT: begin
        cmd.split_step = !status.d_odd;
        cmd.pow_init   = status.d_odd;
        cmd.set_res    = status.d_odd && status.a_zero;
        cmd.res_prime  = 1'b1;
      end
      ST_POW_BIT: begin
        cmd.mul_start = status.e_bit;
        cmd.mul_op    = MUL_ACC_B;
      end
      ST_MUL_ACC: begin
        cmd.mul_op = MUL_ACC_B;
        cmd.wr_acc = status.mul_done;
      end
      ST_POW_SQ: begin
        cmd.mul_start = !status.e_last;
        cmd.exp_shift = !status.e_last;
        cmd.mul_op    = MUL_B_B;
      end
      ST_MUL_B: begin
        cmd.mul_op = MUL_B_B;
        cmd.wr_b   = status.mul_done;
      end
      ST_EVAL: begin
        cmd.mul_op = MUL_ACC_ACC;
        if (status.x_one || status.x_nm1) begin
          cmd.set_res   = 1'b1;
          cmd.res_prime = 1'b1;
        end else if (status.s_last) begin
          cmd.set_res   = 1'b1;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.s_dec     = 1'b1;
        end
      end
      ST_MUL_X: begin
        cmd.mul_op = MUL_ACC_ACC;
        cmd.wr_acc = status.mul_done;
      end
      ST_SQ_EVAL: begin
        cmd.mul_op = MUL_ACC_ACC;
        if (status.x_nm1) begin
          cmd.set_res   = 1'b1;
          cmd.res_prime = 1'b1;
        end else if (status.x_one || status.s_last) begin
          cmd.set_res   = 1'b1;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.s_dec     = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd.emit = out_free;
      end
      default: begin
        cmd.mul_op = MUL_ACC_B;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/miller_rabin_witness_test_core.sv @@
// ----------------------------------------------------------------------------
// miller_rabin_witness_test_core
// One Miller-Rabin round of a candidate n against a single witness a.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+--------------------------------
//   input   | in        | in_valid / in_ready  | candidate, witness
//   result  | out       | out_valid / out_ready| probable_prime, decided_trivially
//
// An item is taken only when the sequencer is idle; one item is worked on at
// a time. Candidates below two, equal to two or even are settled by the
// trivial checks alone. Otherwise the witness is reduced modulo n one bit per
// step, n-1 is split into an odd part and a power of two, and the rest is set
// by the shared shift-add modular multiplier, one product after another.
// Reset is synchronous and active high; it clears the sequencer, the
// multiplier's busy flag and the result register's valid flag.
// A result waits in its own output register, so a stalled result transfer
// does not block the next input transfer; only a second finished result
// waits for the first to be taken.
//
`default_nettype none

module miller_rabin_witness_test_core #(
  parameter int WIDTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [mrwt_pkg::IO_WIDTH-1:0]  candidate,
  input  wire logic [mrwt_pkg::IO_WIDTH-1:0]  witness,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                probable_prime,
  output logic                                decided_trivially
);
  import mrwt_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       res_prime;
  logic       res_triv;
  logic       out_free;

  // The result register can take a new result when it is empty or when its
  // present result is being transferred in this cycle.
  assign out_free = !out_valid || out_ready;

  mrwt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // Only the low WIDTH bits of each input field take part in the test.
  mrwt_datapath #(.W(WIDTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .candidate (candidate[WIDTH-1:0]),
    .witness   (witness[WIDTH-1:0]),
    .cmd       (cmd),
    .status    (status),
    .res_prime (res_prime),
    .res_triv  (res_triv)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      probable_prime    <= res_prime;
      decided_trivially <= res_triv;
    end
  end

endmodule

`default_nettype wire

@@ sv/mrwt_checker.sv @@
// ----------------------------------------------------------------------------
// mrwt_checker
// Port-level checks of the witness test core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "miller_rabin_witness_test_core_macros.svh"

module mrwt_checker #(
  parameter int WIDTH = 64
) (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic [mrwt_pkg::IO_WIDTH-1:0]  candidate,
  input wire logic [mrwt_pkg::IO_WIDTH-1:0]  witness,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic                           probable_prime,
  input wire logic                           decided_trivially
);
  import mrwt_pkg::*;

  logic [WIDTH-1:0] cand_work;
  logic [WIDTH-1:0] cand_out;
  logic [WIDTH-1:0] cand_shown;
  logic             out_valid_q;
  logic             out_xfer_q;
  logic             new_result;
  logic             wit_seen;

  // A fresh result appears when the output was empty or was just taken.
  assign new_result = out_valid && (!out_valid_q || out_xfer_q);
  assign cand_shown = new_result ? cand_work : cand_out;
  assign wit_seen   = (witness == witness);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
      out_xfer_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid;
      out_xfer_q  <= out_valid && out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cand_work <= candidate[WIDTH-1:0];
    end
    cand_out <= cand_shown;
  end

  `MRWT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(probable_prime) && $stable(decided_trivially), "stalled result changed")
  `MRWT_ASSERT_NXT(a_busy_after_take, in_valid && in_ready && wit_seen, !in_ready, "input taken while a round is in progress")
  `MRWT_ASSERT_IMP(a_trivial_value, out_valid && decided_trivially, probable_prime == (cand_shown == WIDTH'(2)), "trivial verdict wrong for the candidate")
  `MRWT_ASSERT_IMP(a_nontrivial_odd, out_valid && !decided_trivially, cand_shown[0] && (cand_shown[WIDTH-1:1] != '0), "exponentiation verdict for a small or even candidate")

endmodule

bind miller_rabin_witness_test_core mrwt_checker #(.WIDTH(WIDTH)) u_mrwt_checker (.*);

`default_nettype wire
